### rtl/core/adsr_pkg.sv
// Shared types, constants and the divider step for the ADSR envelope evaluator.
// No dependencies; imported by adsr_envelope_evaluator.
`timescale 1ns / 1ps

package adsr_pkg;

  // Field widths
  localparam int unsigned TimeW  = 19;
  localparam int unsigned RampW  = 17;
  localparam int unsigned LevelW = 16;
  localparam int unsigned CfgIdxW = 3;

  // Q1.15 full scale
  localparam logic [LevelW-1:0] FULL_SCALE = 16'd32768;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_ATTACK  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DECAY   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SUSTAIN = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DUR     = 3'd4;

  // Reset values
  localparam logic [RampW-1:0]  ATTACK_RST  = 17'd655;
  localparam logic [RampW-1:0]  DECAY_RST   = 17'd655;
  localparam logic [LevelW-1:0] SUSTAIN_RST = 16'd16384;
  localparam logic [RampW-1:0]  RELEASE_RST = 17'd3277;
  localparam logic [TimeW-1:0]  DUR_RST     = 19'd13107;

  // Divider organization: one quotient bit per step
  localparam int unsigned QuoW       = 16;
  localparam int unsigned DivSteps   = 2;
  localparam int unsigned DivStages  = QuoW / DivSteps;
  // operand stage + multiply stage + divider stages + output stage
  localparam int unsigned PipeDepth  = DivStages + 3;

  typedef struct packed {
    logic [RampW-1:0] opa;
    logic [RampW-1:0] opb;
    logic [RampW-1:0] den;
    logic             dec;
  } oper_t;

  typedef struct packed {
    logic [RampW-1:0] rem;
    logic [QuoW-1:0]  nlo;
    logic [QuoW-1:0]  quo;
    logic [RampW-1:0] den;
    logic             dec;
  } div_t;

  // One restoring step: shift in one numerator bit, subtract if it fits.
  // Returns {quotient bit, new remainder}.
  function automatic logic [RampW:0] div_step(input logic [RampW-1:0] rem,
                                              input logic nbit,
                                              input logic [RampW-1:0] den);
    logic [RampW:0] trial;
    logic [RampW:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {1'b1, diff[RampW-1:0]};
    end else begin
      return {1'b0, trial[RampW-1:0]};
    end
  endfunction

endpackage

### rtl/core/adsr_envelope_evaluator.sv
// Top level of the linear ADSR envelope evaluator: operand select, multiply,
// pipelined restoring divider and output stage. Depends on adsr_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel: time_point_i with in_valid_i / in_ready_o, one time point
//   (seconds, 16 fractional bits) per transaction.
//   Output channel: amplitude_o (Q1.15) with out_valid_o / out_ready_i, one
//   amplitude per input transaction, in order.
//   Configuration channel: cfg_index_i / cfg_data_i with cfg_valid_i /
//   cfg_ready_o; cfg_ready_o is always high. Indexes beyond the register list
//   are ignored. Write only while no transaction is in flight.
//   Throughput: one time point per cycle while out_ready_i is high. Input and
//   output are separated by one operand stage, one multiply stage, eight divider
//   stages of two quotient bits each and the output register.
//   Stall: each stage advances when it is empty or its successor advances, so
//   bubbles collapse and the input keeps taking transactions while the output
//   waits, until every stage is full.
//   Reset: all stages empty, registers back to their default envelope.
module adsr_envelope_evaluator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [adsr_pkg::TimeW-1:0]      time_point_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  output logic [adsr_pkg::LevelW-1:0]     amplitude_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  logic [adsr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [adsr_pkg::TimeW-1:0]      cfg_data_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o
);
  import adsr_pkg::*;

  // Configuration registers
  logic [RampW-1:0]  attack_q;
  logic [RampW-1:0]  decay_q;
  logic [LevelW-1:0] sustain_q;
  logic [RampW-1:0]  release_q;
  logic [TimeW-1:0]  dur_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= ATTACK_RST;
      decay_q   <= DECAY_RST;
      sustain_q <= SUSTAIN_RST;
      release_q <= RELEASE_RST;
      dur_q     <= DUR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ATTACK:  attack_q  <= cfg_data_i[RampW-1:0];
        CFG_DECAY:   decay_q   <= cfg_data_i[RampW-1:0];
        CFG_SUSTAIN: sustain_q <= cfg_data_i[LevelW-1:0];
        CFG_RELEASE: release_q <= cfg_data_i[RampW-1:0];
        CFG_DUR:     dur_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage valids and advance enables. Stage 0 holds operands, stage 1 the
  // product, stages 2..PipeDepth-2 the divider, the last one the result.
  logic [PipeDepth-1:0] v_q;
  logic [PipeDepth-1:0] en;

  for (genvar i = 0; i < PipeDepth - 1; i++) begin : g_en
    assign en[i] = !v_q[i] || en[i+1];
  end
  assign en[PipeDepth-1] = !v_q[PipeDepth-1] || out_ready_i;

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < PipeDepth; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // Operand select: pick the envelope segment and map it onto one
  // num / den division. Attack: t*32768 / A. Decay: (32768-S)*(t-A) / D,
  // subtracted from full scale later. Release: S*(R-(t-U)) / R. Flat
  // segments (sustain, decay with S at or above full scale, after release)
  // become level*1 / 1 so the divider hands the level straight through.
  localparam logic [RampW-1:0] One17  = 17'd1;
  localparam logic [RampW-1:0] Full17 = 17'd32768;

  logic [TimeW-1:0] t;
  logic [TimeW-1:0] a_ext;
  logic [TimeW-1:0] since_a;
  logic [TimeW-1:0] since_u;
  logic [TimeW:0]   rel_end;
  oper_t            oper_d;
  oper_t            oper_q;

  always_comb begin
    t       = time_point_i;
    a_ext   = {2'b00, attack_q};
    since_a = t - a_ext;
    since_u = t - dur_q;
    rel_end = {1'b0, dur_q} + {3'b000, release_q};
    oper_d  = '{opa: '0, opb: One17, den: One17, dec: 1'b0};
    if (t < a_ext) begin
      oper_d.opa = t[RampW-1:0];
      oper_d.opb = Full17;
      oper_d.den = attack_q;
    end else if (since_a < {2'b00, decay_q}) begin
      if (sustain_q >= FULL_SCALE) begin
        // ramp would rise above full scale: clamps to full scale
        oper_d.opa = Full17;
      end else begin
        oper_d.opa = since_a[RampW-1:0];
        oper_d.opb = Full17 - {1'b0, sustain_q};
        oper_d.den = decay_q;
        oper_d.dec = 1'b1;
      end
    end else if (t < dur_q) begin
      oper_d.opa = {1'b0, sustain_q};
    end else if ({1'b0, t} < rel_end) begin
      oper_d.opa = {1'b0, sustain_q};
      oper_d.opb = release_q - since_u[RampW-1:0];
      oper_d.den = release_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      oper_q <= oper_d;
    end
  end

  // Multiply; the numerator always stays below den * 2^16, so its upper
  // 17 bits form a starting remainder below den.
  logic [2*RampW-1:0] prod;
  div_t               dv_d [DivStages+1];
  div_t               dv_q [DivStages+1];

  always_comb begin
    prod           = oper_q.opa * oper_q.opb;
    dv_d[0].rem    = prod[QuoW+RampW-1:QuoW];
    dv_d[0].nlo    = prod[QuoW-1:0];
    dv_d[0].quo    = '0;
    dv_d[0].den    = oper_q.den;
    dv_d[0].dec    = oper_q.dec;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      dv_q[0] <= dv_d[0];
    end
  end

  // Divider stages: DivSteps quotient bits each, MSB first
  for (genvar k = 1; k <= DivStages; k++) begin : g_div
    always_comb begin
      logic [RampW:0] step;
      dv_d[k] = dv_q[k-1];
      for (int j = 0; j < DivSteps; j++) begin
        step        = div_step(dv_d[k].rem, dv_d[k].nlo[QuoW-1], dv_d[k].den);
        dv_d[k].rem = step[RampW-1:0];
        dv_d[k].nlo = {dv_d[k].nlo[QuoW-2:0], 1'b0};
        dv_d[k].quo = {dv_d[k].quo[QuoW-2:0], step[RampW]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k+1]) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  // Output stage: decay counts down from full scale, everything else clamps
  logic [LevelW-1:0] quo_fin;
  logic [LevelW-1:0] amp_d;
  logic [LevelW-1:0] amp_q;

  always_comb begin
    quo_fin = dv_q[DivStages].quo;
    if (dv_q[DivStages].dec) begin
      amp_d = FULL_SCALE - quo_fin;
    end else if (quo_fin > FULL_SCALE) begin
      amp_d = FULL_SCALE;
    end else begin
      amp_d = quo_fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[PipeDepth-1]) begin
      amp_q <= amp_d;
    end
  end

  assign amplitude_o = amp_q;
  assign out_valid_o = v_q[PipeDepth-1];

  // Result never exceeds full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (amplitude_o <= FULL_SCALE))
    else $error("amplitude above full scale");

  // Starting remainder below the divisor: the quotient fits 16 bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (dv_q[0].rem < dv_q[0].den))
    else $error("divider numerator out of range");

  // Final remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[PipeDepth-2] |-> (dv_q[DivStages].rem < dv_q[DivStages].den))
    else $error("divider remainder out of range");

  // A full output stage that is not drained holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[PipeDepth-1] && !out_ready_i) |-> !en[PipeDepth-1])
    else $error("output stage overwritten while stalled");

endmodule
